// File: design/mttd_pkg.sv
// shared types, register indexes and the letter table of the morse tone timing decoder
package mttd_pkg;

    typedef enum logic [1:0] {
        CMD_POLL       = 2'd0,
        CMD_TONE_START = 2'd1,
        CMD_TONE_END   = 2'd2
    } cmd_t;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 12;
    localparam int TIME_W    = 32;
    localparam int CHAR_W    = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DOT_MIN    = 3'd0,
        REG_DOT_MAX    = 3'd1,
        REG_DASH_MIN   = 3'd2,
        REG_DASH_MAX   = 3'd3,
        REG_LETTER_GAP = 3'd4,
        REG_WORD_GAP   = 3'd5
    } reg_idx_t;

    localparam logic [CFG_W-1:0] DOT_MIN_RST    = 12'd50;
    localparam logic [CFG_W-1:0] DOT_MAX_RST    = 12'd190;
    localparam logic [CFG_W-1:0] DASH_MIN_RST   = 12'd200;
    localparam logic [CFG_W-1:0] DASH_MAX_RST   = 12'd450;
    localparam logic [CFG_W-1:0] LETTER_GAP_RST = 12'd250;
    localparam logic [CFG_W-1:0] WORD_GAP_RST   = 12'd600;

    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

    localparam int NUM_LETTERS = 26;

    typedef logic [3:0] nib_t;

    // per letter: symbol count and pattern, bit i is symbol i, 1 for dash
    localparam nib_t LETTER_LEN [NUM_LETTERS] = '{
        4'd2, 4'd4, 4'd4, 4'd3, 4'd1, 4'd4, 4'd3, 4'd4, 4'd2, 4'd4, 4'd3, 4'd4, 4'd2,
        4'd2, 4'd3, 4'd4, 4'd4, 4'd3, 4'd3, 4'd1, 4'd3, 4'd4, 4'd3, 4'd4, 4'd4, 4'd4
    };
    localparam nib_t LETTER_BITS [NUM_LETTERS] = '{
        4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
        4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
    };

    // ascii letter for a pattern, CHAR_NONE when no entry matches
    function automatic logic [CHAR_W-1:0] decode_letter(input nib_t len, input nib_t bits);
        logic [CHAR_W-1:0] code;
        code = CHAR_NONE;
        for (int k = NUM_LETTERS - 1; k >= 0; k--) begin
            if (LETTER_LEN[k] == len && LETTER_BITS[k] == bits) begin
                code = CHAR_A + CHAR_W'(k);
            end
        end
        return code;
    endfunction

endpackage

// File: design/morse_tone_timing_decoder.sv
// morse tone timing decoder: timestamped tone events in, decoded characters out
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+----------------------------------
//  s_       | in        | s_tvalid / s_tready    | s_tuser command, s_tdata now_ms
//  m_       | out       | m_tvalid / m_tready    | m_tdata char_code, m_tlast last
//  cfg_     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// while s_tready is high one item is taken per cycle; its results land in a
// three-entry result queue in the same edge; m_ shows the head from the next cycle
// s_tready is high while the queue, after this cycle's pop, holds at most one entry
// cfg_ready is always high
// aresetn is synchronous, active low: registers go to their defaults, queue empties
module morse_tone_timing_decoder #(
    parameter int MAX_SYMBOLS = 9
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // [31:0] now_ms
    input  logic [1:0]                      s_tuser,   // [1:0] command
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [6:0] char_code, [7] zero
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mttd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mttd_pkg::CFG_W-1:0]      cfg_data
);

    localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
    localparam int QD    = 3;
    localparam int QC_W  = 2;

    typedef struct packed {
        logic [mttd_pkg::CHAR_W-1:0] code;
        logic                        last;
    } res_t;

    logic [mttd_pkg::CFG_W-1:0] dot_min_reg, dot_max_reg, dash_min_reg, dash_max_reg;
    logic [mttd_pkg::CFG_W-1:0] letter_gap_reg, word_gap_reg;

    logic [mttd_pkg::TIME_W-1:0] tone_start_reg, tone_start_next;
    logic [mttd_pkg::TIME_W-1:0] silence_start_reg, silence_start_next;
    logic                        tone_active_reg, tone_active_next;
    logic                        space_sent_reg, space_sent_next;
    logic [MAX_SYMBOLS-1:0]      pattern_reg, pattern_next;
    logic [CNT_W-1:0]            count_reg, count_next;

    res_t            q_reg [QD];
    res_t            q_next [QD];
    logic [QC_W-1:0] qcnt_reg, qcnt_next;

    logic                        in_acc, pop;
    logic [QC_W-1:0]             qbase;
    mttd_pkg::cmd_t              cmd;
    logic [mttd_pkg::TIME_W-1:0] dur, silence;
    logic                        is_dot, is_dash;
    logic [mttd_pkg::CHAR_W-1:0] letter;
    logic                        letter_ok;
    logic [1:0]                  nres;
    res_t                        res0, res1;

    assign cfg_ready = 1'b1;
    assign pop       = m_tvalid && m_tready;
    assign qbase     = qcnt_reg - QC_W'(pop);
    assign s_tready  = (qbase <= QC_W'(1));
    assign in_acc    = s_tvalid && s_tready;
    assign m_tvalid  = (qcnt_reg != '0);
    assign m_tdata   = {1'b0, q_reg[0].code};
    assign m_tlast   = q_reg[0].last;

    assign cmd     = mttd_pkg::cmd_t'(s_tuser);
    assign dur     = s_tdata - tone_start_reg;
    assign silence = s_tdata - silence_start_reg;
    assign is_dot  = (dur >= 32'(dot_min_reg)) && (dur < 32'(dot_max_reg));
    assign is_dash = (dur >= 32'(dash_min_reg)) && (dur < 32'(dash_max_reg));

    assign letter    = mttd_pkg::decode_letter(4'(count_reg), pattern_reg[3:0]);
    assign letter_ok = (letter != mttd_pkg::CHAR_NONE) && ((pattern_reg >> 4) == '0);

    // state update and results of the incoming item
    always_comb begin
        logic close_letter, send_space, emit_letter;
        tone_start_next    = tone_start_reg;
        silence_start_next = silence_start_reg;
        tone_active_next   = tone_active_reg;
        space_sent_next    = space_sent_reg;
        pattern_next       = pattern_reg;
        count_next         = count_reg;
        nres               = 2'd0;
        res0               = '{code: mttd_pkg::CHAR_SPACE, last: 1'b1};
        res1               = '{code: mttd_pkg::CHAR_SPACE, last: 1'b1};
        close_letter       = 1'b0;
        send_space         = 1'b0;
        emit_letter        = 1'b0;
        if (in_acc) begin
            unique case (cmd)
                mttd_pkg::CMD_TONE_START: begin
                    tone_start_next  = s_tdata;
                    tone_active_next = 1'b1;
                    space_sent_next  = 1'b0;
                end
                mttd_pkg::CMD_TONE_END: begin
                    silence_start_next = s_tdata;
                    tone_active_next   = 1'b0;
                    if ((is_dot || is_dash) && count_reg < CNT_W'(MAX_SYMBOLS)) begin
                        pattern_next = pattern_reg
                                     | (MAX_SYMBOLS'(!is_dot) << count_reg);
                        count_next   = count_reg + CNT_W'(1);
                    end
                end
                mttd_pkg::CMD_POLL: begin
                    if (!tone_active_reg) begin
                        close_letter = (silence > 32'(letter_gap_reg)) && (count_reg != '0);
                        send_space   = (silence > 32'(word_gap_reg)) && !space_sent_reg;
                        emit_letter  = close_letter && letter_ok;
                        if (close_letter) begin
                            pattern_next = '0;
                            count_next   = '0;
                        end
                        if (send_space) begin
                            space_sent_next = 1'b1;
                        end
                        if (emit_letter) begin
                            res0 = '{code: letter, last: !send_space};
                        end
                        nres = 2'(emit_letter) + 2'(send_space);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result queue: pop from the head, append behind what stays
    always_comb begin
        for (int i = 0; i < QD; i++) begin
            if (pop && i < QD - 1) begin
                q_next[i] = q_reg[i+1];
            end else begin
                q_next[i] = q_reg[i];
            end
            if (nres != 2'd0 && QC_W'(i) == qbase) begin
                q_next[i] = res0;
            end
            if (nres == 2'd2 && QC_W'(i) == qbase + QC_W'(1)) begin
                q_next[i] = res1;
            end
        end
        qcnt_next = qbase + QC_W'(nres);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_min_reg       <= mttd_pkg::DOT_MIN_RST;
            dot_max_reg       <= mttd_pkg::DOT_MAX_RST;
            dash_min_reg      <= mttd_pkg::DASH_MIN_RST;
            dash_max_reg      <= mttd_pkg::DASH_MAX_RST;
            letter_gap_reg    <= mttd_pkg::LETTER_GAP_RST;
            word_gap_reg      <= mttd_pkg::WORD_GAP_RST;
            tone_start_reg    <= '0;
            silence_start_reg <= '0;
            tone_active_reg   <= 1'b0;
            space_sent_reg    <= 1'b1;
            pattern_reg       <= '0;
            count_reg         <= '0;
            qcnt_reg          <= '0;
        end else begin
            tone_start_reg    <= tone_start_next;
            silence_start_reg <= silence_start_next;
            tone_active_reg   <= tone_active_next;
            space_sent_reg    <= space_sent_next;
            pattern_reg       <= pattern_next;
            count_reg         <= count_next;
            qcnt_reg          <= qcnt_next;
            if (cfg_valid && cfg_ready) begin
                unique case (mttd_pkg::reg_idx_t'(cfg_index))
                    mttd_pkg::REG_DOT_MIN:    dot_min_reg    <= cfg_data;
                    mttd_pkg::REG_DOT_MAX:    dot_max_reg    <= cfg_data;
                    mttd_pkg::REG_DASH_MIN:   dash_min_reg   <= cfg_data;
                    mttd_pkg::REG_DASH_MAX:   dash_max_reg   <= cfg_data;
                    mttd_pkg::REG_LETTER_GAP: letter_gap_reg <= cfg_data;
                    mttd_pkg::REG_WORD_GAP:   word_gap_reg   <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QD; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

// File: tb/mttd_char_checker.sv
// checker for the morse tone timing decoder: tracks decoder state, predicts characters, compares
module mttd_char_checker #(
    parameter int MAX_SYMBOLS = 9
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [31:0]                     s_tdata,
    input  logic [1:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [7:0]                      m_tdata,
    input  logic                            m_tlast,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [mttd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mttd_pkg::CFG_W-1:0]      cfg_data,
    output int                              mismatches,
    output int                              chars_due
);
    timeunit 1ns;
    timeprecision 1ps;
    import mttd_pkg::*;

    localparam logic [CHAR_W-1:0] SPACE_CODE = 7'h20;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } char_item_t;

    char_item_t              due_q[$];
    logic [CFG_W-1:0]        dot_lo, dot_hi, dash_lo, dash_hi, letter_gap, word_gap;
    logic [TIME_W-1:0]       tone_t0, quiet_t0;
    logic                    tone_on, word_closed;
    logic [MAX_SYMBOLS-1:0]  sym_bits;
    logic [3:0]              sym_count;
    int                      fail_n;

    // key is {symbol count, first four symbols}, dash is 1, first symbol in bit 0
    function automatic logic [CHAR_W-1:0] letter_of(input logic [3:0] cnt,
                                                    input logic [MAX_SYMBOLS-1:0] bits);
        logic [7:0] ascii;
        case ({cnt, bits[3:0]})
            8'h22: ascii = "A";
            8'h41: ascii = "B";
            8'h45: ascii = "C";
            8'h31: ascii = "D";
            8'h10: ascii = "E";
            8'h44: ascii = "F";
            8'h33: ascii = "G";
            8'h40: ascii = "H";
            8'h20: ascii = "I";
            8'h4E: ascii = "J";
            8'h35: ascii = "K";
            8'h42: ascii = "L";
            8'h23: ascii = "M";
            8'h21: ascii = "N";
            8'h37: ascii = "O";
            8'h46: ascii = "P";
            8'h4B: ascii = "Q";
            8'h32: ascii = "R";
            8'h30: ascii = "S";
            8'h11: ascii = "T";
            8'h34: ascii = "U";
            8'h48: ascii = "V";
            8'h36: ascii = "W";
            8'h49: ascii = "X";
            8'h4D: ascii = "Y";
            8'h43: ascii = "Z";
            default: ascii = 8'h00;
        endcase
        return ascii[CHAR_W-1:0];
    endfunction

    task automatic note_event(input logic [1:0] cmd, input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] span;
        logic [CHAR_W-1:0] letter;
        logic [CHAR_W-1:0] codes [2];
        logic              is_sym, is_dash;
        char_item_t        item;
        int                n;
        n = 0;
        case (cmd)
            CMD_TONE_START: begin
                tone_t0 = now;
                tone_on = 1'b1;
                word_closed = 1'b0;
            end
            CMD_TONE_END: begin
                span = now - tone_t0;
                quiet_t0 = now;
                tone_on = 1'b0;
                is_sym = 1'b1;
                is_dash = 1'b0;
                if (span >= dot_lo && span < dot_hi) begin
                    is_dash = 1'b0;
                end else if (span >= dash_lo && span < dash_hi) begin
                    is_dash = 1'b1;
                end else begin
                    is_sym = 1'b0;
                end
                if (is_sym && sym_count < MAX_SYMBOLS) begin
                    sym_bits[sym_count] = is_dash;
                    sym_count = sym_count + 4'd1;
                end
            end
            CMD_POLL: begin
                if (!tone_on) begin
                    span = now - quiet_t0;
                    if (span > letter_gap && sym_count != 0) begin
                        letter = letter_of(sym_count, sym_bits);
                        if (letter != '0) begin
                            codes[n] = letter;
                            n++;
                        end
                        sym_count = '0;
                        sym_bits = '0;
                    end
                    if (span > word_gap && !word_closed) begin
                        codes[n] = SPACE_CODE;
                        n++;
                        word_closed = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        for (int i = 0; i < n; i++) begin
            item.code = codes[i];
            item.last = (i == n - 1);
            due_q.push_back(item);
        end
    endtask

    task automatic flag(input string what, input logic [CHAR_W-1:0] exp_code,
                        input logic exp_last);
        if (fail_n < REPORT_LIMIT) begin
            $display("chk: %s: expected char %02h last %0b, got char %02h last %0b at %0t",
                     what, exp_code, exp_last, m_tdata[CHAR_W-1:0], m_tlast, $realtime);
        end
        fail_n++;
    endtask

    always @(posedge aclk) begin
        char_item_t head;
        if (!aresetn) begin
            dot_lo = DOT_MIN_RST;
            dot_hi = DOT_MAX_RST;
            dash_lo = DASH_MIN_RST;
            dash_hi = DASH_MAX_RST;
            letter_gap = LETTER_GAP_RST;
            word_gap = WORD_GAP_RST;
            tone_t0 = '0;
            quiet_t0 = '0;
            tone_on = 1'b0;
            word_closed = 1'b1;
            sym_bits = '0;
            sym_count = '0;
            fail_n = 0;
            due_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_q.size() == 0) begin
                    flag("unexpected item", '0, 1'b0);
                end else begin
                    head = due_q.pop_front();
                    if (m_tdata[CHAR_W-1:0] != head.code) begin
                        flag("char_code mismatch", head.code, head.last);
                    end else if (m_tlast != head.last) begin
                        flag("last mismatch", head.code, head.last);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DOT_MIN:    dot_lo = cfg_data;
                    REG_DOT_MAX:    dot_hi = cfg_data;
                    REG_DASH_MIN:   dash_lo = cfg_data;
                    REG_DASH_MAX:   dash_hi = cfg_data;
                    REG_LETTER_GAP: letter_gap = cfg_data;
                    REG_WORD_GAP:   word_gap = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                note_event(s_tuser, s_tdata);
            end
        end
        mismatches <= fail_n;
        chars_due <= due_q.size();
    end

endmodule

// File: tb/tb_top.sv
// testbench top for the morse tone timing decoder: clock, reset, stimulus and verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mttd_pkg::*;

    localparam int         SYMBOL_LIMIT     = 9;
    localparam logic [1:0] CMD_IGNORED      = 2'd3;
    localparam int         LONG_HOLD_CYCLES = 300;
    localparam int         TAIL_CYCLES      = 8;
    localparam int         CFG_MAX          = 4095;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;
    int                    mismatches;
    int                    chars_due;

    // stimulus side copy of the timing registers, used only to aim durations and gaps
    int                    dot_lo, dot_hi, dash_lo, dash_hi, letter_gap, word_gap;
    logic [31:0]           t_ms, last_end;
    int                    items_sent;
    bit                    calm;
    bit                    hold_req;

    morse_tone_timing_decoder #(
        .MAX_SYMBOLS(SYMBOL_LIMIT)
    ) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    mttd_char_checker #(
        .MAX_SYMBOLS(SYMBOL_LIMIT)
    ) u_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mismatches(mismatches), .chars_due(chars_due)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // receiver: random stalls, one long hold on request, none once calm
    initial begin
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [31:0] now);
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= now;
        do @(posedge aclk); while (!s_tready);
        if (cmd != CMD_IGNORED) begin
            items_sent++;
        end
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    task automatic tone(input logic [31:0] start, input logic [31:0] len);
        send_item(CMD_TONE_START, start);
        send_item(CMD_TONE_END, start + len);
        last_end = start + len;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (chars_due != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic load_timing(input int d_lo, input int d_hi, input int a_lo, input int a_hi,
                               input int l_gap, input int w_gap);
        settle();
        write_reg(REG_DOT_MIN, d_lo);
        write_reg(REG_DOT_MAX, d_hi);
        write_reg(REG_DASH_MIN, a_lo);
        write_reg(REG_DASH_MAX, a_hi);
        write_reg(REG_LETTER_GAP, l_gap);
        write_reg(REG_WORD_GAP, w_gap);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        dot_lo = d_lo;
        dot_hi = d_hi;
        dash_lo = a_lo;
        dash_hi = a_hi;
        letter_gap = l_gap;
        word_gap = w_gap;
    endtask

    task automatic load_random_timing();
        int d_lo, d_hi, a_lo, a_hi, l_gap;
        d_lo = $urandom_range(20, 80);
        d_hi = d_lo + $urandom_range(50, 150);
        a_lo = d_hi + $urandom_range(0, 30);
        a_hi = a_lo + $urandom_range(100, 300);
        l_gap = $urandom_range(100, 400);
        load_timing(d_lo, d_hi, a_lo, a_hi, l_gap, l_gap + $urandom_range(100, 500));
    endtask

    function automatic logic [31:0] pick_len();
        int k;
        k = $urandom_range(0, 15);
        if (k <= 5) begin
            return (dot_hi > dot_lo) ? $urandom_range(dot_lo, dot_hi - 1)
                                     : $urandom_range(0, CFG_MAX);
        end else if (k <= 10) begin
            return (dash_hi > dash_lo) ? $urandom_range(dash_lo, dash_hi - 1)
                                       : $urandom_range(0, CFG_MAX);
        end else if (k == 11) begin
            case ($urandom_range(0, 3))
                0: return dot_lo - 1;
                1: return dot_lo;
                2: return dot_hi - 1;
                default: return dot_hi;
            endcase
        end else if (k == 12) begin
            case ($urandom_range(0, 3))
                0: return dash_lo - 1;
                1: return dash_lo;
                2: return dash_hi - 1;
                default: return dash_hi;
            endcase
        end else if (k == 13) begin
            return $urandom_range(0, CFG_MAX);
        end else if (k == 14) begin
            return $urandom();
        end
        return '0;
    endfunction

    // one letter: a run of tones, then polls that close the letter and maybe the word
    task automatic play_letter();
        int n_sym;
        n_sym = ($urandom_range(0, 9) == 0) ? $urandom_range(5, SYMBOL_LIMIT + 3)
                                            : $urandom_range(1, 4);
        for (int i = 0; i < n_sym; i++) begin
            tone(t_ms, pick_len());
            if ($urandom_range(0, 5) == 0) begin
                send_item(CMD_POLL, last_end + $urandom_range(0, letter_gap));
            end
            t_ms = last_end + $urandom_range(1, 300);
        end
        case ($urandom_range(0, 7))
            0: begin
                send_item(CMD_POLL, last_end + letter_gap);
                send_item(CMD_POLL, last_end + letter_gap + 1);
            end
            1, 2, 3, 4: send_item(CMD_POLL, last_end + letter_gap + 1 + $urandom_range(0, 40));
            5, 6: send_item(CMD_POLL, last_end + word_gap + 1 + $urandom_range(0, 100));
            default: begin
                send_item(CMD_POLL, last_end + letter_gap + 1);
                send_item(CMD_POLL, last_end + word_gap + 1);
            end
        endcase
        t_ms = last_end + word_gap + $urandom_range(2, 200);
    endtask

    task automatic broken_sequence();
        case ($urandom_range(0, 2))
            0: begin
                last_end = t_ms + pick_len();
                send_item(CMD_TONE_END, last_end);
            end
            1: begin
                send_item(CMD_TONE_START, t_ms);
                tone(t_ms + $urandom_range(0, 500), pick_len());
            end
            default: begin
                send_item(CMD_TONE_START, t_ms);
                send_item(CMD_POLL, t_ms + $urandom_range(0, 5000));
                last_end = t_ms + pick_len();
                send_item(CMD_TONE_END, last_end);
            end
        endcase
        t_ms = last_end + $urandom_range(1, 300);
    endtask

    task automatic traffic(input int n);
        int goal;
        int k;
        goal = items_sent + n;
        while (items_sent < goal) begin
            k = $urandom_range(0, 9);
            if (k < 7) begin
                play_letter();
            end else if (k == 7) begin
                send_item(2'($urandom_range(0, 3)), $urandom());
            end else if (k == 8) begin
                broken_sequence();
            end else begin
                case ($urandom_range(0, 4))
                    0: send_item(CMD_POLL, last_end + letter_gap);
                    1: send_item(CMD_POLL, last_end + letter_gap + 1);
                    2: send_item(CMD_POLL, last_end + word_gap);
                    3: send_item(CMD_POLL, last_end + word_gap + 1);
                    default: send_item(CMD_POLL, last_end + $urandom());
                endcase
            end
        end
    endtask

    initial begin
        s_tvalid <= 1'b0;
        s_tuser <= CMD_POLL;
        s_tdata <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_DOT_MIN;
        cfg_data <= '0;
        aresetn <= 1'b0;
        calm = 1'b0;
        hold_req = 1'b0;
        items_sent = 0;
        dot_lo = int'(DOT_MIN_RST);
        dot_hi = int'(DOT_MAX_RST);
        dash_lo = int'(DASH_MIN_RST);
        dash_hi = int'(DASH_MAX_RST);
        letter_gap = int'(LETTER_GAP_RST);
        word_gap = int'(WORD_GAP_RST);
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset timers, window edges, restart, ignored commands, wraparound
        send_item(CMD_POLL, 32'd0);
        send_item(CMD_TONE_END, 32'd100);
        send_item(CMD_POLL, 32'd351);
        send_item(CMD_TONE_START, 32'd400);
        send_item(CMD_IGNORED, 32'hFFFF_FFFF);
        send_item(CMD_TONE_END, 32'd650);
        send_item(CMD_TONE_START, 32'd700);
        send_item(CMD_TONE_START, 32'd710);
        send_item(CMD_TONE_END, 32'd760);
        send_item(CMD_POLL, 32'd1010);
        send_item(CMD_POLL, 32'd1361);
        send_item(CMD_TONE_START, 32'd2000);
        send_item(CMD_POLL, 32'd9000);
        send_item(CMD_TONE_END, 32'd2190);
        send_item(CMD_TONE_START, 32'd2300);
        send_item(CMD_TONE_END, 32'd2499);
        tone(32'd3000, 32'd449);
        tone(32'd3500, 32'd450);
        tone(32'd4000, 32'd200);
        tone(32'hFFFF_FFF0, 32'h70);
        send_item(CMD_POLL, 32'h60 + 32'd601);

        t_ms = $urandom();
        last_end = t_ms;
        traffic(350);

        load_random_timing();
        hold_req = 1'b1;
        traffic(400);

        load_timing(0, CFG_MAX, 0, CFG_MAX, 0, 0);
        traffic(200);

        load_timing(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
        traffic(150);

        // overlapping windows
        load_timing(100, 300, 200, 500, 300, 700);
        traffic(350);

        load_random_timing();
        traffic(300);

        load_timing(int'(DOT_MIN_RST), int'(DOT_MAX_RST), int'(DASH_MIN_RST),
                    int'(DASH_MAX_RST), int'(LETTER_GAP_RST), int'(WORD_GAP_RST));
        calm = 1'b1;
        traffic(250);

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/mttd_pkg.sv
design/morse_tone_timing_decoder.sv
tb/mttd_char_checker.sv
tb/tb_top.sv
